/* design/dcc_pkg.sv */
package dcc_pkg;

  // magazine slots and limits
  localparam int MAG_SLOTS = 4;
  localparam int MAG_REGS  = 4;
  localparam int SLOT_W    = (MAG_SLOTS > 1) ? $clog2(MAG_SLOTS) : 1;

  localparam logic [6:0]  AMMO_CAP   = 7'd99;
  localparam logic [31:0] TIMEOUT_US = 32'd2000000;
  localparam logic [23:0] SPEED_MAX  = 24'hFFFFFF;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  // divider: 24 bit dividend, 32 bit divisor
  localparam int DIV_N_W   = 24;
  localparam int DIV_D_W   = 32;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // tick queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USE_LIGHT_GATE = 4'd0,
    REG_CHRONO_ENABLE  = 4'd1,
    REG_TRIP_PERCENT   = 4'd2,
    REG_DART_LENGTH    = 4'd3,
    REG_MAG_SIZE_A     = 4'd4,
    REG_MAG_SIZE_B     = 4'd5,
    REG_MAG_SIZE_C     = 4'd6,
    REG_MAG_SIZE_D     = 4'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CHRONO_NONE    = 2'd0,
    CHRONO_SPEED   = 2'd1,
    CHRONO_TIMEOUT = 2'd2
  } chrono_status_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_DIV  = 1'b1
  } back_state_t;

  typedef logic [MAG_REGS-1:0][6:0] mag_sizes_t;

  typedef struct packed {
    logic        use_light_gate;
    logic        chrono_enable;
    logic [6:0]  trip_percent;
    logic [19:0] dart_length_ufeet;
    mag_sizes_t  mag_size;
  } cfg_t;

  // classified tick passed from front to back
  typedef struct packed {
    logic [31:0] time_us;
    logic        tripped;
    logic        clear;
    logic        shot;
    logic        insert;
    logic        toggle;
  } tick_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

  // capacity of a slot, clamped to the count limit; slots without a register read 0
  function automatic logic [6:0] cap_of(input logic [SLOT_W-1:0] slot,
                                        input mag_sizes_t sizes);
    logic [6:0] c;
    c = '0;
    for (int i = 0; i < MAG_REGS; i++) begin
      if ((SLOT_W+4)'(slot) == (SLOT_W+4)'(i)) begin
        c = sizes[i];
      end
    end
    return (c > AMMO_CAP) ? AMMO_CAP : c;
  endfunction

endpackage

/* design/dcc_if.sv */
// input tick channel
interface dcc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_us;
  logic [9:0]  gate_level;
  logic        shot_press;
  logic        insert_press;
  logic        toggle_press;

  modport source (output valid, time_us, gate_level, shot_press, insert_press,
                  toggle_press, input ready);
  modport sink   (input valid, time_us, gate_level, shot_press, insert_press,
                  toggle_press, output ready);
endinterface

// result channel
interface dcc_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  ammo_count;
  logic [23:0] speed_q4;
  logic [1:0]  chrono_status;

  modport source (output valid, ammo_count, speed_q4, chrono_status, input ready);
  modport sink   (input valid, ammo_count, speed_q4, chrono_status, output ready);
endinterface

/* design/dcc_front.sv */
module dcc_front (
  dcc_in_if.sink         in_ch,
  input  logic [6:0]     trip_percent,
  input  logic           q_full,
  output logic           q_push,
  output dcc_pkg::tick_t q_tick
);

  logic [16:0] scaled;
  logic [6:0]  pct_est;
  logic [10:0] pct_rem;
  logic [6:0]  pct;

  // level percent = level*100/1023, via x/1024 plus one correction step
  always_comb begin
    scaled  = 17'(in_ch.gate_level) * 17'd100;
    pct_est = scaled[16:10];
    pct_rem = 11'(scaled[9:0]) + 11'(pct_est);
    pct     = (pct_rem >= 11'd1023) ? pct_est + 7'd1 : pct_est;
  end

  // classify and hand over to the queue
  always_comb begin
    q_tick.time_us = in_ch.time_us;
    q_tick.tripped = (pct > trip_percent);
    q_tick.clear   = (pct < trip_percent);
    q_tick.shot    = in_ch.shot_press;
    q_tick.insert  = in_ch.insert_press;
    q_tick.toggle  = in_ch.toggle_press;
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

endmodule

/* design/dcc_queue.sv */
module dcc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dcc_pkg::tick_t push_tick,
  input  logic           pop,
  output dcc_pkg::tick_t head_tick,
  output logic           full,
  output logic           empty
);

  dcc_pkg::tick_t                       mem_r [dcc_pkg::QUEUE_DEPTH];
  logic [dcc_pkg::QUEUE_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [dcc_pkg::QUEUE_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [dcc_pkg::QUEUE_CNT_W-1:0]      count_r, count_nxt;

  assign full      = (count_r == dcc_pkg::QUEUE_CNT_W'(dcc_pkg::QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_tick = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tick;
    end
  end

endmodule

/* design/dcc_divider.sv */
module dcc_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  dcc_pkg::div_req_t req,
  output dcc_pkg::div_rsp_t rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [dcc_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [dcc_pkg::DIV_D_W-1:0]    rem_r, rem_nxt;
  logic [dcc_pkg::DIV_N_W-1:0]    quo_r, quo_nxt;
  logic [dcc_pkg::DIV_D_W-1:0]    dsr_r, dsr_nxt;
  logic [dcc_pkg::DIV_D_W:0]      trial;
  logic [dcc_pkg::DIV_D_W:0]      diff;

  // one restoring step per cycle, quotient bits shift in from the right
  always_comb begin
    trial    = {rem_r, quo_r[dcc_pkg::DIV_N_W-1]};
    diff     = trial - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!diff[dcc_pkg::DIV_D_W]) begin
        rem_nxt = diff[dcc_pkg::DIV_D_W-1:0];
        quo_nxt = {quo_r[dcc_pkg::DIV_N_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[dcc_pkg::DIV_D_W-1:0];
        quo_nxt = {quo_r[dcc_pkg::DIV_N_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == dcc_pkg::DIV_CNT_W'(dcc_pkg::DIV_N_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* design/dcc_back.sv */
module dcc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  dcc_pkg::cfg_t     cfg,
  input  dcc_pkg::tick_t    tick,
  input  logic              q_empty,
  output logic              q_pop,
  output dcc_pkg::div_req_t div_req,
  input  dcc_pkg::div_rsp_t div_rsp,
  dcc_out_if.source         out_ch
);

  dcc_pkg::back_state_t          state_r, state_nxt;
  logic [6:0]                    ammo_r, ammo_nxt;
  logic [dcc_pkg::SLOT_W-1:0]    slot_r, slot_nxt;
  logic                          gate_tripped_r, gate_tripped_nxt;
  logic [31:0]                   stamp_r, stamp_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [6:0]                    out_ammo_r, out_ammo_nxt;
  logic [23:0]                   out_speed_r, out_speed_nxt;
  dcc_pkg::chrono_status_t       out_status_r, out_status_nxt;

  logic                          out_free;
  logic                          take;
  logic [dcc_pkg::SLOT_W:0]      slot_inc;
  logic [dcc_pkg::SLOT_W-1:0]    slot_new;
  logic [6:0]                    cap;
  logic [6:0]                    ammo_load;
  logic [6:0]                    ammo_shot;
  logic [31:0]                   elapsed;
  logic                          need_div;

  assign out_free = !out_valid_r || out_ch.ready;
  assign take     = (state_r == dcc_pkg::BK_IDLE) && !q_empty && out_free;
  assign q_pop    = take;

  // slot step, reload and shot count for the tick at the head of the queue
  always_comb begin
    slot_inc  = {1'b0, slot_r} + 1'b1;
    if (slot_inc < (dcc_pkg::SLOT_W+1)'(dcc_pkg::MAG_SLOTS)) begin
      slot_new = tick.toggle ? slot_inc[dcc_pkg::SLOT_W-1:0] : slot_r;
    end else begin
      slot_new = tick.toggle ? '0 : slot_r;
    end
    cap       = dcc_pkg::cap_of(slot_new, cfg.mag_size);
    ammo_load = (tick.toggle || tick.insert) ? cap : ammo_r;
    if (cap == '0) begin
      ammo_shot = (ammo_load < dcc_pkg::AMMO_CAP) ? ammo_load + 7'd1 : ammo_load;
    end else begin
      ammo_shot = (ammo_load != '0) ? ammo_load - 7'd1 : ammo_load;
    end
    elapsed  = tick.time_us - stamp_r;
    need_div = cfg.chrono_enable && gate_tripped_r && tick.clear && (elapsed != '0);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dcc_pkg::BK_IDLE: begin
        if (take && need_div) begin
          state_nxt = dcc_pkg::BK_DIV;
        end
      end
      dcc_pkg::BK_DIV: begin
        if (div_rsp.done) begin
          state_nxt = dcc_pkg::BK_IDLE;
        end
      end
      default: state_nxt = dcc_pkg::BK_IDLE;
    endcase
  end

  // state updates and result register
  always_comb begin
    ammo_nxt         = ammo_r;
    slot_nxt         = slot_r;
    gate_tripped_nxt = gate_tripped_r;
    stamp_nxt        = stamp_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_ammo_nxt     = out_ammo_r;
    out_speed_nxt    = out_speed_r;
    out_status_nxt   = out_status_r;
    div_req.start    = 1'b0;
    div_req.dividend = {cfg.dart_length_ufeet, 4'b0000};
    div_req.divisor  = elapsed;

    if (take) begin
      slot_nxt       = slot_new;
      ammo_nxt       = ammo_load;
      out_speed_nxt  = '0;
      out_status_nxt = dcc_pkg::CHRONO_NONE;
      if (!cfg.chrono_enable) begin
        if (cfg.use_light_gate ? tick.tripped : tick.shot) begin
          ammo_nxt = ammo_shot;
        end
      end else if (!gate_tripped_r && tick.tripped) begin
        gate_tripped_nxt = 1'b1;
        stamp_nxt        = tick.time_us;
      end else if (gate_tripped_r && tick.clear) begin
        gate_tripped_nxt = 1'b0;
        ammo_nxt         = ammo_shot;
        out_speed_nxt    = dcc_pkg::SPEED_MAX;
        out_status_nxt   = dcc_pkg::CHRONO_SPEED;
        div_req.start    = need_div;
      end else if (gate_tripped_r && (elapsed > dcc_pkg::TIMEOUT_US)) begin
        gate_tripped_nxt = 1'b0;
        out_status_nxt   = dcc_pkg::CHRONO_TIMEOUT;
      end
      out_ammo_nxt = ammo_nxt;
      if (!need_div) begin
        out_valid_nxt = 1'b1;
      end
    end else if ((state_r == dcc_pkg::BK_DIV) && div_rsp.done) begin
      // quotient never exceeds 24 bits, so no saturation needed here
      out_valid_nxt  = 1'b1;
      out_ammo_nxt   = ammo_r;
      out_speed_nxt  = div_rsp.quotient;
      out_status_nxt = dcc_pkg::CHRONO_SPEED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= dcc_pkg::BK_IDLE;
      ammo_r         <= '0;
      slot_r         <= '0;
      gate_tripped_r <= 1'b0;
      stamp_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      ammo_r         <= ammo_nxt;
      slot_r         <= slot_nxt;
      gate_tripped_r <= gate_tripped_nxt;
      stamp_r        <= stamp_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ammo_r   <= out_ammo_nxt;
    out_speed_r  <= out_speed_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.ammo_count    = out_ammo_r;
  assign out_ch.speed_q4      = out_speed_r;
  assign out_ch.chrono_status = out_status_r;

endmodule

/* design/dart_counter_chronograph.sv */
// Dart counter and chronograph. One result per input tick, in order. A tick
// passes the front (gate threshold test) into a two-entry queue; the back
// then handles it, so plain ticks flow at one per cycle while the result
// register drains. A tick that ends a speed measurement (beam exit with
// nonzero elapsed time) runs the restoring divider, one quotient bit per
// cycle: 24 steps plus start and finish. Registers are written on cfg_we
// with cfg_index and cfg_data; write them only while no tick is in flight.
module dart_counter_chronograph (
  input  logic                             clk,
  input  logic                             rst_n,
  dcc_in_if.sink                           in_ch,
  dcc_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [dcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dcc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  dcc_pkg::cfg_t     cfg_r, cfg_nxt;
  dcc_pkg::tick_t    push_tick;
  dcc_pkg::tick_t    head_tick;
  logic              q_push, q_pop, q_full, q_empty;
  dcc_pkg::div_req_t div_req;
  dcc_pkg::div_rsp_t div_rsp;

  // register writes, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (dcc_pkg::cfg_reg_t'(cfg_index))
        dcc_pkg::REG_USE_LIGHT_GATE: cfg_nxt.use_light_gate    = cfg_data[0];
        dcc_pkg::REG_CHRONO_ENABLE:  cfg_nxt.chrono_enable     = cfg_data[0];
        dcc_pkg::REG_TRIP_PERCENT:   cfg_nxt.trip_percent      = cfg_data[6:0];
        dcc_pkg::REG_DART_LENGTH:    cfg_nxt.dart_length_ufeet = cfg_data[19:0];
        dcc_pkg::REG_MAG_SIZE_A:     cfg_nxt.mag_size[0]       = cfg_data[6:0];
        dcc_pkg::REG_MAG_SIZE_B:     cfg_nxt.mag_size[1]       = cfg_data[6:0];
        dcc_pkg::REG_MAG_SIZE_C:     cfg_nxt.mag_size[2]       = cfg_data[6:0];
        dcc_pkg::REG_MAG_SIZE_D:     cfg_nxt.mag_size[3]       = cfg_data[6:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.use_light_gate    <= 1'b0;
      cfg_r.chrono_enable     <= 1'b0;
      cfg_r.trip_percent      <= 7'd95;
      cfg_r.dart_length_ufeet <= 20'd236221;
      cfg_r.mag_size          <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dcc_front u_front (
    .in_ch        (in_ch),
    .trip_percent (cfg_r.trip_percent),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_tick       (push_tick)
  );

  dcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tick (push_tick),
    .pop       (q_pop),
    .head_tick (head_tick),
    .full      (q_full),
    .empty     (q_empty)
  );

  dcc_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  dcc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .tick    (head_tick),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_ch  (out_ch)
  );

`ifndef ASSERT_OFF
  // speed is only reported with a new reading
  a_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.chrono_status != dcc_pkg::CHRONO_SPEED)
      |-> (out_ch.speed_q4 == '0))
    else $error("speed nonzero without a reading");

  // count never passes the limit
  a_ammo_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.ammo_count <= dcc_pkg::AMMO_CAP))
    else $error("ammo count above limit");

  // no chrono status outside chrono mode
  a_no_chrono: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !cfg_r.chrono_enable
      |-> (out_ch.chrono_status == dcc_pkg::CHRONO_NONE))
    else $error("chrono status outside chrono mode");

  // a pop never happens on an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule
